// ===== rtl/core/sptw_pkg.sv =====
// Package for the Sv39 page table walker.
// Holds field widths, entry bit positions, codes, state type and the slot reducer request struct.
// No dependencies.
`timescale 1ns / 1ps

package sptw_pkg;

  localparam int TABLE_PAGES_DEF  = 8;
  localparam int ENTRIES_PER_PAGE = 512;
  localparam int PAGE_IDX_W       = 9;

  localparam int IDX_W    = 12;
  localparam int DATA_W   = 64;
  localparam int VA_W     = 64;
  localparam int PPN_W    = 44;
  localparam int MAXVA_W  = 40;
  localparam int BASE_W   = 56;
  localparam int CFG_W    = 44;
  localparam int PG_OFS_W = 12;

  localparam logic [MAXVA_W-1:0] MAX_VA_RST = 40'h40_0000_0000;

  // entry bits
  localparam int PTE_V       = 0;
  localparam int PTE_R       = 1;
  localparam int PTE_W       = 2;
  localparam int PTE_X       = 3;
  localparam int PTE_U       = 4;
  localparam int PTE_PPN_LSB = 10;

  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_WALK  = 1'b1
  } sptw_op_t;

  typedef enum logic {
    CFG_ROOT = 1'b0,
    CFG_MAX  = 1'b1
  } sptw_cfg_t;

  typedef enum logic [2:0] {
    STS_OK       = 3'd0,
    STS_RANGE    = 3'd1,
    STS_UNMAPPED = 3'd2,
    STS_NOT_USER = 3'd3,
    STS_WRITTEN  = 3'd4
  } sptw_status_t;

  typedef enum logic [1:0] {
    LVL_LEAF = 2'd0,
    LVL_MID  = 2'd1,
    LVL_ROOT = 2'd2
  } sptw_level_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_REDUCE,
    S_EVAL,
    S_RESP
  } sptw_state_t;

  typedef struct packed {
    logic             start;
    logic [PPN_W-1:0] ppn;
  } sptw_red_req_t;

endpackage

// ===== rtl/core/sptw_in_if.sv =====
// Input channel of the page table walker: entry write or translation request.
// Depends on sptw_pkg.
`timescale 1ns / 1ps

interface sptw_in_if import sptw_pkg::*; ();
  logic              valid;
  logic              ready;
  sptw_op_t          op;
  logic [IDX_W-1:0]  entry_index;
  logic [DATA_W-1:0] entry_data;
  logic [VA_W-1:0]   virtual_address;

  modport source (output valid, op, entry_index, entry_data, virtual_address, input ready);
  modport sink   (input valid, op, entry_index, entry_data, virtual_address, output ready);
endinterface

// ===== rtl/core/sptw_out_if.sv =====
// Result channel of the page table walker.
// Depends on sptw_pkg.
`timescale 1ns / 1ps

interface sptw_out_if import sptw_pkg::*; ();
  logic              valid;
  logic              ready;
  sptw_status_t      status;
  logic [BASE_W-1:0] physical_base;
  logic              is_superpage;

  modport source (output valid, status, physical_base, is_superpage, input ready);
  modport sink   (input valid, status, physical_base, is_superpage, output ready);
endinterface

// ===== rtl/core/sptw_store.sv =====
// Entry store: one write port, one read port with registered read data.
// Depends on sptw_pkg. Contents are not reset.
`timescale 1ns / 1ps

module sptw_store import sptw_pkg::*; #(
  parameter int TABLE_PAGES = TABLE_PAGES_DEF
) (
  input  logic                                              clk,
  input  logic                                              wr_en,
  input  logic [$clog2(TABLE_PAGES*ENTRIES_PER_PAGE)-1:0]   wr_addr,
  input  logic [DATA_W-1:0]                                 wr_data,
  input  logic                                              rd_en,
  input  logic [$clog2(TABLE_PAGES*ENTRIES_PER_PAGE)-1:0]   rd_addr,
  output logic [DATA_W-1:0]                                 rd_data
);

  localparam int DEPTH = TABLE_PAGES * ENTRIES_PER_PAGE;

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== rtl/core/sptw_slot_reduce.sv =====
// Shared page-number to slot reducer: page number mod TABLE_PAGES.
// Registered mask for a power of two, else one byte per cycle. Depends on sptw_pkg.
`timescale 1ns / 1ps

module sptw_slot_reduce import sptw_pkg::*; #(
  parameter int TABLE_PAGES = TABLE_PAGES_DEF
) (
  input  logic                                              clk,
  input  logic                                              rst_n,
  input  sptw_red_req_t                                     req,
  output logic                                              done,
  output logic [((TABLE_PAGES > 1) ? $clog2(TABLE_PAGES) : 1)-1:0] slot
);

  localparam int SLOT_W = (TABLE_PAGES > 1) ? $clog2(TABLE_PAGES) : 1;

  if ((TABLE_PAGES & (TABLE_PAGES - 1)) == 0) begin : g_pow2
    logic              done_r;
    logic [SLOT_W-1:0] slot_r;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        done_r <= 1'b0;
      end else begin
        done_r <= req.start;
      end
    end

    always_ff @(posedge clk) begin
      if (req.start) begin
        slot_r <= SLOT_W'(req.ppn % PPN_W'(TABLE_PAGES));
      end
    end

    assign done = done_r;
    assign slot = slot_r;
  end else begin : g_serial
    localparam int STEPS = (PPN_W + 7) / 8;
    localparam int PAD_W = STEPS * 8;
    localparam int CNT_W = $clog2(STEPS + 1);
    localparam int ACC_W = SLOT_W + 9;

    logic [PAD_W-1:0]  val_r;
    logic [SLOT_W-1:0] rem_r;
    logic [SLOT_W-1:0] rem_nxt;
    logic [CNT_W-1:0]  cnt_r;
    logic              busy_r;
    logic              done_r;

    // restoring reduction of one byte appended to the running remainder
    function automatic logic [SLOT_W-1:0] reduce_byte(input logic [ACC_W-1:0] a);
      logic [ACC_W-1:0] acc;
      acc = a;
      for (int i = 7; i >= 0; i--) begin
        if (acc >= (ACC_W'(TABLE_PAGES) << i)) begin
          acc = acc - (ACC_W'(TABLE_PAGES) << i);
        end
      end
      return acc[SLOT_W-1:0];
    endfunction

    always_comb begin
      rem_nxt = reduce_byte({1'b0, rem_r, val_r[PAD_W-1 -: 8]});
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        busy_r <= 1'b0;
        done_r <= 1'b0;
        cnt_r  <= '0;
      end else begin
        done_r <= 1'b0;
        if (req.start) begin
          busy_r <= 1'b1;
          cnt_r  <= '0;
        end else if (busy_r) begin
          cnt_r <= cnt_r + CNT_W'(1);
          if (cnt_r == CNT_W'(STEPS - 1)) begin
            busy_r <= 1'b0;
            done_r <= 1'b1;
          end
        end
      end
    end

    always_ff @(posedge clk) begin
      if (req.start) begin
        val_r <= PAD_W'(req.ppn);
        rem_r <= '0;
      end else if (busy_r) begin
        val_r <= val_r << 8;
        rem_r <= rem_nxt;
      end
    end

    assign done = done_r;
    assign slot = rem_r;
  end

endmodule

// ===== rtl/core/sv39_page_table_walker.sv =====
// Sv39 page table walker over a small store of table pages.
// An entry write passes S_RESP before out valid is registered; a range reject passes S_CHECK
// and S_RESP; each level walked adds the slot reducer (a mask for power-of-two TABLE_PAGES,
// a byte-serial reduction otherwise) and the registered store read in S_REDUCE and S_EVAL.
// One item at a time: the next transfer is taken the cycle after the result is loaded, which
// waits while an earlier result is held. Reset clears control state, not the entry store.
`timescale 1ns / 1ps

module sv39_page_table_walker import sptw_pkg::*; #(
  parameter int TABLE_PAGES = TABLE_PAGES_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  sptw_in_if.sink          in_ch,
  sptw_out_if.source       out_ch,
  input  logic             cfg_we,
  input  sptw_cfg_t        cfg_index,
  input  logic [CFG_W-1:0] cfg_data
);

  localparam int SLOT_W      = (TABLE_PAGES > 1) ? $clog2(TABLE_PAGES) : 1;
  localparam int STORE_WORDS = TABLE_PAGES * ENTRIES_PER_PAGE;
  localparam int ADDR_W      = $clog2(STORE_WORDS);

  sptw_state_t        state_r, state_nxt;
  logic [PPN_W-1:0]   root_r;
  logic [MAXVA_W-1:0] max_va_r;
  logic [VA_W-1:0]    va_r, va_nxt;
  sptw_level_t        lvl_r, lvl_nxt;
  sptw_status_t       res_status_r, res_status_nxt;
  logic [BASE_W-1:0]  res_base_r, res_base_nxt;
  logic               res_super_r, res_super_nxt;
  logic               out_valid_r, out_valid_nxt;
  sptw_status_t       out_status_r, out_status_nxt;
  logic [BASE_W-1:0]  out_base_r, out_base_nxt;
  logic               out_super_r, out_super_nxt;

  sptw_red_req_t      red_req;
  logic               red_done;
  logic [SLOT_W-1:0]  red_slot;

  logic               mem_we;
  logic               mem_rd_en;
  logic [ADDR_W-1:0]  mem_wr_addr;
  logic [ADDR_W-1:0]  mem_rd_addr;
  logic [DATA_W-1:0]  mem_rd_data;
  logic [PAGE_IDX_W-1:0] page_idx;
  logic [DATA_W-1:0]  pte;

  sptw_slot_reduce #(.TABLE_PAGES(TABLE_PAGES)) u_reduce (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (red_req),
    .done  (red_done),
    .slot  (red_slot)
  );

  sptw_store #(.TABLE_PAGES(TABLE_PAGES)) u_store (
    .clk     (clk),
    .wr_en   (mem_we),
    .wr_addr (mem_wr_addr),
    .wr_data (in_ch.entry_data),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      root_r   <= '0;
      max_va_r <= MAX_VA_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ROOT: root_r   <= cfg_data[PPN_W-1:0];
        CFG_MAX:  max_va_r <= cfg_data[MAXVA_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (lvl_r)
      LVL_ROOT: page_idx = va_r[38:30];
      LVL_MID:  page_idx = va_r[29:21];
      default:  page_idx = va_r[20:12];
    endcase
  end

  assign mem_wr_addr = ADDR_W'(in_ch.entry_index);
  assign mem_rd_addr = ADDR_W'({red_slot, page_idx});
  assign pte         = mem_rd_data;
  assign in_ch.ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt      = state_r;
    va_nxt         = va_r;
    lvl_nxt        = lvl_r;
    res_status_nxt = res_status_r;
    res_base_nxt   = res_base_r;
    res_super_nxt  = res_super_r;
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    out_status_nxt = out_status_r;
    out_base_nxt   = out_base_r;
    out_super_nxt  = out_super_r;
    red_req        = '0;
    mem_we         = 1'b0;
    mem_rd_en      = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          res_base_nxt  = '0;
          res_super_nxt = 1'b0;
          if (in_ch.op == OP_WRITE) begin
            mem_we         = 32'(in_ch.entry_index) < 32'(STORE_WORDS);
            res_status_nxt = STS_WRITTEN;
            state_nxt      = S_RESP;
          end else begin
            va_nxt    = in_ch.virtual_address;
            state_nxt = S_CHECK;
          end
        end
      end
      S_CHECK: begin
        if (va_r >= VA_W'(max_va_r)) begin
          res_status_nxt = STS_RANGE;
          state_nxt      = S_RESP;
        end else begin
          red_req.start = 1'b1;
          red_req.ppn   = root_r;
          lvl_nxt       = LVL_ROOT;
          state_nxt     = S_REDUCE;
        end
      end
      S_REDUCE: begin
        if (red_done) begin
          mem_rd_en = 1'b1;
          state_nxt = S_EVAL;
        end
      end
      S_EVAL: begin
        if (!pte[PTE_V]) begin
          res_status_nxt = STS_UNMAPPED;
          state_nxt      = S_RESP;
        end else if (lvl_r == LVL_ROOT ||
                     (lvl_r == LVL_MID && pte[PTE_X:PTE_R] == 3'b000)) begin
          // follow as pointer
          red_req.start = 1'b1;
          red_req.ppn   = pte[PTE_PPN_LSB +: PPN_W];
          lvl_nxt       = (lvl_r == LVL_ROOT) ? LVL_MID : LVL_LEAF;
          state_nxt     = S_REDUCE;
        end else begin
          state_nxt = S_RESP;
          if (!pte[PTE_U]) begin
            res_status_nxt = STS_NOT_USER;
          end else begin
            res_status_nxt = STS_OK;
            res_base_nxt   = {pte[PTE_PPN_LSB +: PPN_W], {PG_OFS_W{1'b0}}};
            res_super_nxt  = (lvl_r == LVL_MID);
          end
        end
      end
      S_RESP: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_base_nxt   = res_base_r;
          out_super_nxt  = res_super_r;
          state_nxt      = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    va_r         <= va_nxt;
    lvl_r        <= lvl_nxt;
    res_status_r <= res_status_nxt;
    res_base_r   <= res_base_nxt;
    res_super_r  <= res_super_nxt;
    out_status_r <= out_status_nxt;
    out_base_r   <= out_base_nxt;
    out_super_r  <= out_super_nxt;
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.status        = out_status_r;
  assign out_ch.physical_base = out_base_r;
  assign out_ch.is_superpage  = out_super_r;

  a_read_then_eval: assert property (@(posedge clk) disable iff (!rst_n)
    mem_rd_en |=> state_r == S_EVAL)
    else $error("store read not followed by entry evaluation");

  a_reduce_in_walk: assert property (@(posedge clk) disable iff (!rst_n)
    red_done |-> state_r == S_REDUCE)
    else $error("slot reduction finished outside a walk step");

  a_result_from_resp: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_RESP))
    else $error("result raised outside response state");

  a_super_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_super_r) |-> out_status_r == STS_OK)
    else $error("superpage flag on a failed translation");

  a_fault_zero_base: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r != STS_OK) |-> out_base_r == '0)
    else $error("nonzero base on a fault or write result");

endmodule

// ===== tb/testbench.sv =====
// Testbench for sv39_page_table_walker: entry writes and Sv39 translations through the
// valid/ready channels, checked against a built-in walk predictor. Depends on sptw_pkg,
// sptw_in_if, sptw_out_if and the walker RTL.
`timescale 1ns / 1ps

module testbench;
  import sptw_pkg::*;

  localparam int STORE_WORDS = TABLE_PAGES_DEF * ENTRIES_PER_PAGE;
  localparam int IDLE_LIMIT  = 4000;

  typedef struct packed {
    sptw_op_t          op;
    logic [IDX_W-1:0]  idx;
    logic [DATA_W-1:0] data;
    logic [VA_W-1:0]   va;
  } walk_item_t;

  typedef struct packed {
    sptw_status_t      status;
    logic [BASE_W-1:0] base;
    logic              superpage;
  } walk_result_t;

  typedef enum logic [2:0] {
    WALK_OK4K,
    WALK_OK2M,
    WALK_L2_RWX,
    WALK_BAD_L2,
    WALK_BAD_L1,
    WALK_BAD_L0,
    WALK_NOUSER_2M,
    WALK_NOUSER_4K
  } walk_mode_t;

  logic             clk;
  logic             rst_n;
  logic             cfg_we;
  sptw_cfg_t        cfg_index;
  logic [CFG_W-1:0] cfg_data;

  sptw_in_if  in_ch();
  sptw_out_if out_ch();

  sv39_page_table_walker uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // predictor state, updated at transfers and register writes
  logic [PPN_W-1:0]   model_root;
  logic [MAXVA_W-1:0] model_max;
  logic [DATA_W-1:0]  model_store [STORE_WORDS];

  // stimulus planning copy, runs ahead of the transfers
  logic [DATA_W-1:0]  plan_store [STORE_WORDS];
  bit                 plan_written [STORE_WORDS];
  int                 planned_items;

  walk_item_t   pending_items[$];
  walk_result_t expected_results[$];
  walk_item_t   drive_item;
  walk_result_t want;
  logic         in_taken;
  int           burst_left;
  int           gap_left;
  int           stall_mode;
  int           stall_count;
  logic [31:0]  stall_bits;
  int           idle_cycles;
  int           mismatch_count;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic int entry_addr(logic [PPN_W-1:0] ppn, logic [PAGE_IDX_W-1:0] idx);
    return int'(ppn % TABLE_PAGES_DEF) * ENTRIES_PER_PAGE + int'(idx);
  endfunction

  function automatic walk_result_t predict_result(walk_item_t it);
    walk_result_t      r;
    logic [PPN_W-1:0]  ppn;
    logic [DATA_W-1:0] pte;
    int                lvl;
    bit                leaf_found;
    r.status    = STS_OK;
    r.base      = '0;
    r.superpage = 1'b0;
    if (it.op == OP_WRITE) begin
      r.status = STS_WRITTEN;
      return r;
    end
    if (it.va >= model_max) begin
      r.status = STS_RANGE;
      return r;
    end
    ppn = model_root;
    leaf_found = 1'b0;
    lvl = LVL_ROOT;
    while (!leaf_found) begin
      pte = model_store[entry_addr(ppn, it.va[PG_OFS_W + PAGE_IDX_W*lvl +: PAGE_IDX_W])];
      if (!pte[PTE_V]) begin
        r.status = STS_UNMAPPED;
        return r;
      end
      ppn = pte[PTE_PPN_LSB +: PPN_W];
      // level 2 is always a pointer; level 1 with R/W/X is a 2 MiB leaf
      r.superpage = (lvl == LVL_MID) && (pte[PTE_X:PTE_R] != 3'b000);
      leaf_found = r.superpage || (lvl == LVL_LEAF);
      lvl--;
    end
    if (!pte[PTE_U]) begin
      r.status = STS_NOT_USER;
      r.superpage = 1'b0;
      return r;
    end
    r.base = {ppn, PG_OFS_W'(0)};
    return r;
  endfunction

  task automatic report_mismatch(string msg);
    $display("%0t ns: %s", $time, msg);
    mismatch_count++;
  endtask

  task automatic push_item(sptw_op_t op, logic [IDX_W-1:0] idx, logic [DATA_W-1:0] data,
                           logic [VA_W-1:0] va);
    walk_item_t it;
    it.op   = op;
    it.idx  = idx;
    it.data = data;
    it.va   = va;
    pending_items.push_back(it);
    planned_items++;
  endtask

  task automatic push_write(logic [IDX_W-1:0] idx, logic [DATA_W-1:0] data);
    plan_store[idx]   = data;
    plan_written[idx] = 1'b1;
    push_item(OP_WRITE, idx, data, {$urandom, $urandom});
  endtask

  // Writes whatever entries the walk of va needs (all unwritten ones, plus the forced
  // levels) so that no unwritten entry is ever read, then queues the translation.
  task automatic push_walk(logic [VA_W-1:0] va, walk_mode_t mode, logic [2:0] force_mask);
    logic [PPN_W-1:0]  ppn;
    logic [DATA_W-1:0] pte;
    logic [2:0]        redo;
    int                lvl;
    int                addr;
    bit                wrote;
    bit                stop;
    bit                leaf;
    redo = force_mask;
    leaf = (mode == WALK_OK2M) || (mode == WALK_NOUSER_2M);
    if (va < model_max) begin
      do begin
        wrote = 1'b0;
        stop  = 1'b0;
        ppn   = model_root;
        for (lvl = LVL_ROOT; !stop; lvl--) begin
          addr = entry_addr(ppn, va[PG_OFS_W + PAGE_IDX_W*lvl +: PAGE_IDX_W]);
          if (!plan_written[addr] || redo[lvl]) begin
            redo[lvl] = 1'b0;
            pte = {$urandom, $urandom};
            case (lvl)
              LVL_ROOT: begin
                pte[PTE_V] = (mode != WALK_BAD_L2);
                pte[PTE_X:PTE_R] = (mode == WALK_L2_RWX) ? 3'($urandom_range(1, 7)) : 3'b000;
              end
              LVL_MID: begin
                pte[PTE_V] = (mode != WALK_BAD_L1);
                pte[PTE_X:PTE_R] = leaf ? 3'($urandom_range(1, 7)) : 3'b000;
                if (leaf) pte[PTE_U] = (mode != WALK_NOUSER_2M);
              end
              default: begin
                pte[PTE_V] = (mode != WALK_BAD_L0);
                pte[PTE_U] = (mode != WALK_NOUSER_4K);
              end
            endcase
            push_write(IDX_W'(addr), pte);
            wrote = 1'b1;
          end
          pte  = plan_store[addr];
          stop = !pte[PTE_V] || (lvl == LVL_LEAF) ||
                 ((lvl == LVL_MID) && (pte[PTE_X:PTE_R] != 3'b000));
          ppn  = pte[PTE_PPN_LSB +: PPN_W];
        end
      end while (wrote);
    end
    push_item(OP_WALK, IDX_W'($urandom), {$urandom, $urandom}, va);
  endtask

  task automatic write_register(sptw_cfg_t sel, logic [CFG_W-1:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= sel;
    cfg_data  <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (sel == CFG_ROOT) model_root = value[PPN_W-1:0];
    else model_max = value[MAXVA_W-1:0];
  endtask

  task automatic wait_idle(int settle);
    do @(posedge clk);
    while (pending_items.size() != 0 || in_ch.valid || expected_results.size() != 0);
    repeat (settle) @(negedge clk);
  endtask

  // sender: bursts of random length with random gaps
  always @(negedge clk) begin
    if (in_taken || !in_ch.valid) begin
      if (gap_left > 0) begin
        gap_left--;
        in_ch.valid <= 1'b0;
      end else if (pending_items.size() != 0) begin
        drive_item = pending_items.pop_front();
        in_ch.op              <= drive_item.op;
        in_ch.entry_index     <= drive_item.idx;
        in_ch.entry_data      <= drive_item.data;
        in_ch.virtual_address <= drive_item.va;
        in_ch.valid           <= 1'b1;
        if (burst_left <= 1) begin
          burst_left = $urandom_range(1, 40);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        end else begin
          burst_left--;
        end
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // receiver: stall mode is redrawn whenever its random countdown runs out
  always @(negedge clk) begin
    if (stall_count == 0) begin
      stall_mode  <= $urandom_range(0, 3);
      stall_count <= $urandom_range(20, 120);
      stall_bits  <= $urandom | 32'h1;
    end else begin
      stall_count <= stall_count - 1;
    end
    case (stall_mode)
      0:       out_ch.ready <= 1'b1;
      1:       out_ch.ready <= ($urandom_range(0, 3) != 0);
      2:       out_ch.ready <= ($urandom_range(0, 3) == 0);
      default: out_ch.ready <= stall_bits[stall_count[4:0]];
    endcase
  end

  always @(posedge clk) begin
    in_taken <= in_ch.valid && in_ch.ready;
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_results.size() == 0) begin
          report_mismatch($sformatf("result transfer with nothing expected: status %0d",
                                    out_ch.status));
        end else begin
          want = expected_results.pop_front();
          if (out_ch.status != want.status)
            report_mismatch($sformatf("status %0d, expected %0d", out_ch.status, want.status));
          if (out_ch.physical_base != want.base)
            report_mismatch($sformatf("physical_base %h, expected %h",
                                      out_ch.physical_base, want.base));
          if (out_ch.is_superpage != want.superpage)
            report_mismatch($sformatf("is_superpage %0b, expected %0b",
                                      out_ch.is_superpage, want.superpage));
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        expected_results.push_back(predict_result({in_ch.op, in_ch.entry_index,
                                                   in_ch.entry_data, in_ch.virtual_address}));
        if (in_ch.op == OP_WRITE) model_store[in_ch.entry_index] = in_ch.entry_data;
      end
    end
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("sv39_page_table_walker regression: fail");
      $finish;
    end
  end

  initial begin
    int               ph;
    int               target;
    int               start;
    int               pick;
    logic [VA_W-1:0]  va;
    logic [PPN_W-1:0] next_root;
    logic [CFG_W-1:0] next_max;
    rst_n                 = 1'b0;
    cfg_we                = 1'b0;
    cfg_index             = CFG_ROOT;
    cfg_data              = '0;
    in_ch.valid           = 1'b0;
    in_ch.op              = OP_WRITE;
    in_ch.entry_index     = '0;
    in_ch.entry_data      = '0;
    in_ch.virtual_address = '0;
    out_ch.ready          = 1'b0;
    in_taken              = 1'b0;
    burst_left            = 0;
    gap_left              = 0;
    stall_mode            = 0;
    stall_count           = 0;
    stall_bits            = 32'h1;
    idle_cycles           = 0;
    mismatch_count        = 0;
    planned_items         = 0;
    model_root            = '0;
    model_max             = MAX_VA_RST;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;

    // directed: every walk outcome under the reset register values
    push_walk(64'h0, WALK_OK4K, 3'b111);
    push_walk(64'h20_0000, WALK_OK2M, 3'b011);
    push_walk(64'h40_0000, WALK_NOUSER_2M, 3'b011);
    push_walk(64'h60_0000, WALK_BAD_L1, 3'b011);
    push_walk(64'h1000, WALK_BAD_L0, 3'b001);
    push_walk(64'h2000, WALK_NOUSER_4K, 3'b001);
    push_walk(64'h4000_0000, WALK_BAD_L2, 3'b111);
    push_walk(64'h8000_0000, WALK_L2_RWX, 3'b111);
    push_walk(VA_W'(MAX_VA_RST) - 1, WALK_OK4K, 3'b111);
    push_walk(VA_W'(MAX_VA_RST), WALK_OK4K, 3'b000);
    push_walk('1, WALK_OK4K, 3'b000);
    push_write('1, '1);

    for (ph = 0; ph < 7; ph++) begin
      wait_idle(4);
      target = 210;
      case (ph)
        0: begin
          next_root = '1;
          next_max  = CFG_W'(64'h80_0000_0000);
        end
        1: begin
          next_root = '0;
          next_max  = '0;
          target    = 30;
        end
        2: begin
          next_root = {$urandom, $urandom};
          next_max  = CFG_W'(MAX_VA_RST);
        end
        5: begin
          next_root = {$urandom, $urandom};
          next_max  = CFG_W'($urandom_range(4096, 32'h40_0000));
        end
        default: begin
          next_root = {$urandom, $urandom};
          next_max  = CFG_W'(({$urandom, $urandom} % 64'h80_0000_0000) + 1);
        end
      endcase
      write_register(CFG_ROOT, CFG_W'(next_root));
      write_register(CFG_MAX, next_max);

      start = planned_items;
      while (planned_items - start < target) begin
        pick = $urandom_range(0, 99);
        if (pick < 8) begin
          push_write(IDX_W'($urandom), {$urandom, $urandom});
        end else if (pick < 16) begin
          push_walk({$urandom, $urandom}, walk_mode_t'($urandom_range(0, 7)), 3'b000);
        end else begin
          va = {$urandom, $urandom};
          if (model_max != 0) va = va % model_max;
          if (pick < 22) va = VA_W'(model_max) + $urandom_range(0, 1) - 1;
          push_walk(va, walk_mode_t'($urandom_range(0, 7)),
                    3'($urandom_range(0, 7)) & 3'($urandom_range(0, 7)));
        end
      end
    end

    wait_idle(16);
    if (mismatch_count == 0) begin
      $display("sv39_page_table_walker regression: pass");
    end else begin
      $display("sv39_page_table_walker regression: fail");
    end
    $finish;
  end

endmodule
